/* src/afu_pkg.sv */
// Package for the activation function unit: number format constants,
// payload structs, function codes, clip helper and the interpolation tables.
// Has no dependencies; used by every module under src.
package afu_pkg;

	// Number format
	localparam int DATA_BITS        = 16;
	localparam int FRAC_BITS        = 12;
	localparam int TABLE_INDEX_BITS = 8;

	localparam int IDX_BITS  = (TABLE_INDEX_BITS < DATA_BITS) ? TABLE_INDEX_BITS : DATA_BITS;
	localparam int LERP_BITS = DATA_BITS - IDX_BITS;
	localparam int R_W       = (LERP_BITS > 0) ? LERP_BITS : 1;
	localparam int TAB_LEN   = (1 << IDX_BITS) + 1;
	localparam int TAB_W     = FRAC_BITS + 2;
	localparam int DIFF_W    = TAB_W + 1;
	localparam int IPROD_W   = DIFF_W + R_W + 1;
	localparam int WIDE_OP   = (DATA_BITS > FRAC_BITS + 2) ? DATA_BITS : FRAC_BITS + 2;
	localparam int OPB_W     = WIDE_OP + 1;
	localparam int PROD_W    = DATA_BITS + OPB_W;
	localparam int YW        = 2 * WIDE_OP + R_W + 6;

	localparam logic [DATA_BITS-1:0] LERP_MASK = DATA_BITS'((64'd1 << LERP_BITS) - 64'd1);
	localparam logic signed [YW-1:0] ONE_Y     = YW'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [YW-1:0] DMAX_Y    = YW'((64'sd1 <<< (DATA_BITS - 1)) - 64'sd1);
	localparam logic signed [YW-1:0] DMIN_Y    = -YW'(64'sd1 <<< (DATA_BITS - 1));

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ACT_KIND   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_MODE = 2'd1;

	// Function codes; 6 and 7 behave as identity
	typedef enum logic [2:0] {
		ACT_IDENTITY  = 3'd0,
		ACT_HEAVISIDE = 3'd1,
		ACT_LOGISTIC  = 3'd2,
		ACT_RELU      = 3'd3,
		ACT_TANH      = 3'd4,
		ACT_SIGMOID   = 3'd5
	} act_kind_t;

	// Payloads
	typedef struct packed {
		logic signed [DATA_BITS-1:0] sample_in;
		logic                        last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] sample_out;
		logic                        invalid;
		logic                        saturated;
		logic                        last_out;
	} out_item_t;

	// Load enables handed to the interpolator
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} interp_en_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] val;
		logic                        sat;
	} clip_t;

	// Clip a wide value to the sample range
	function automatic clip_t sat_clip(input logic signed [YW-1:0] v);
		clip_t c;
		c.sat = 1'b0;
		if (v > DMAX_Y) begin
			c.val = DATA_BITS'(DMAX_Y);
			c.sat = 1'b1;
		end else if (v < DMIN_Y) begin
			c.val = DATA_BITS'(DMIN_Y);
			c.sat = 1'b1;
		end else begin
			c.val = DATA_BITS'(v);
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Table generation, evaluated at elaboration only.
	// Q60 integer exponentials, then correctly rounded table points.
	// ------------------------------------------------------------------
	localparam logic [63:0] Q60_ONE = 64'd1 << 60;

	function automatic logic [63:0] mulq60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Restoring shift-subtract division
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-f), f in [0,1], Q60
	function automatic logic [63:0] exp_unit(input logic [63:0] f);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		term = Q60_ONE;
		pos  = Q60_ONE;
		neg  = '0;
		for (int k = 1; k <= 30; k++) begin
			term = udiv64(mulq60(term, f), 64'(k));
			if (k % 2 == 1) neg = neg + term;
			else pos = pos + term;
		end
		return pos - neg;
	endfunction

	// exp(-m / 2^FRAC_BITS), Q60
	function automatic logic [63:0] exp_neg(input logic [63:0] m, input logic [63:0] e1);
		logic [63:0] n;
		logic [63:0] fr;
		logic [63:0] r;
		n  = m >> FRAC_BITS;
		fr = m & ((64'd1 << FRAC_BITS) - 64'd1);
		if (n >= 64'd48) return 64'd0;
		r = exp_unit(fr << (60 - FRAC_BITS));
		for (int i = 0; i < 48; i++) begin
			if (64'(i) < n) r = mulq60(r, e1);
		end
		return r;
	endfunction

	typedef logic [TAB_LEN-1:0][TAB_W-1:0] tab_t;

	function automatic tab_t build_table(input logic is_tanh);
		tab_t               t;
		logic [63:0]        e1;
		logic signed [63:0] p;
		logic [63:0]        m;
		logic [63:0]        e;
		logic [63:0]        d;
		logic [63:0]        num;
		logic [63:0]        q;
		e1 = exp_unit(Q60_ONE);
		for (int k = 0; k < TAB_LEN; k++) begin
			p = (64'(k) <<< LERP_BITS) - (64'sd1 <<< (DATA_BITS - 1));
			m = (p < 0) ? 64'(-p) : 64'(p);
			if (is_tanh) begin
				e   = (exp_neg(m << 1, e1) + (64'd1 << 23)) >> 24;
				d   = (64'd1 << 36) + e;
				num = ((64'd1 << 36) - e) << FRAC_BITS;
				q   = udiv64((num << 1) + d, d << 1);
				t[k] = (p < 0) ? TAB_W'(-q) : TAB_W'(q);
			end else begin
				e   = (exp_neg(m, e1) + (64'd1 << 23)) >> 24;
				d   = (64'd1 << 36) + e;
				num = (p >= 0) ? (64'd1 << (36 + FRAC_BITS)) : (e << FRAC_BITS);
				t[k] = TAB_W'(udiv64((num << 1) + d, d << 1));
			end
		end
		return t;
	endfunction

	localparam tab_t SIG_TAB  = build_table(1'b0);
	localparam tab_t TANH_TAB = build_table(1'b1);

endpackage

/* src/activation_function_unit.sv */
// Top level of the activation function unit: config registers, valid/stall
// pipeline control, product stage and result select. Uses afu_pkg, afu_interp.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one Q4.12 sample and
//   its last flag; a transfer happens when in_valid is high and in_stall low.
//   Output channel out_valid / out_stall / out_data returns one result per
//   sample, in order, with invalid, saturated and last_out flags.
//   Config: cfg_we with cfg_index 0 writes act_kind, 1 writes derivative_mode;
//   write only while no samples are in flight. Other indexes are ignored.
// Timing:
//   Five register stages (input, table read, interpolation, product, output).
//   The input register loads on the input transfer edge; the sample then passes
//   through the table read, interpolation, product and output registers, and
//   out_valid rises; the output transfer can come on the next edge. One sample
//   per cycle sustained while out_stall is low; interpolation and derivative multiply each own a stage.
// Reset:
//   arst_n clears all stage valids and sets act_kind identity, forward mode.
// Backpressure:
//   out_stall holds the output register; each stage keeps loading while the
//   stage after it has room, so bubbles close up and in_stall rises only when
//   every stage is full.
module activation_function_unit import afu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	act_kind_t act_kind_q;
	logic      deriv_mode_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// Stage payloads
	logic signed [DATA_BITS-1:0] x_s1, x_s2, x_s3, x_s4;
	logic                        last_s1, last_s2, last_s3, last_s4;
	act_kind_t                   kind_s1, kind_s2, kind_s3, kind_s4;
	logic                        deriv_s1, deriv_s2, deriv_s3, deriv_s4;
	logic signed [DATA_BITS-1:0] t_s3;
	logic                        lsat_s3;
	logic signed [DATA_BITS-1:0] t_s4;
	logic                        lsat_s4;
	logic signed [PROD_W-1:0]    prod_s4;
	out_item_t                   out_s5;

	interp_en_t                  ien;
	logic                        sel_tanh;
	logic                        use_lut;
	logic signed [DATA_BITS-1:0] op_a;
	logic signed [OPB_W-1:0]     op_b;
	logic signed [YW-1:0]        shr;
	logic signed [YW-1:0]        y;
	logic                        inv;
	clip_t                       yc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_kind_q   <= ACT_IDENTITY;
			deriv_mode_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_ACT_KIND) act_kind_q <= act_kind_t'(cfg_data);
			else if (cfg_index == REG_DERIV_MODE) deriv_mode_q <= cfg_data[0];
		end
	end

	// Stage ready chain: a stage loads when it is empty or drains
	assign rdy5     = !v_s5 || !out_stall;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: input register, config sampled with the item
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x_s1     <= in_data.sample_in;
			last_s1  <= in_data.last_in;
			kind_s1  <= act_kind_q;
			deriv_s1 <= deriv_mode_q;
		end
	end

	// Which kinds read a table
	always_comb begin
		sel_tanh = (kind_s1 == ACT_TANH);
		case (kind_s1) inside
			ACT_TANH, ACT_SIGMOID: use_lut = 1'b1;
			ACT_LOGISTIC:          use_lut = !deriv_s1;
			default:               use_lut = 1'b0;
		endcase
	end

	assign ien.ld_s2 = rdy2 && v_s1;
	assign ien.ld_s3 = rdy3 && v_s2;

	afu_interp u_interp (
		.clk      (clk),
		.en       (ien),
		.x        (x_s1),
		.sel_tanh (sel_tanh),
		.use_lut  (use_lut),
		.t_s3     (t_s3),
		.lsat_s3  (lsat_s3)
	);

	// Side payload through stages 2 and 3
	always_ff @(posedge clk) begin
		if (ien.ld_s2) begin
			x_s2     <= x_s1;
			last_s2  <= last_s1;
			kind_s2  <= kind_s1;
			deriv_s2 <= deriv_s1;
		end
		if (ien.ld_s3) begin
			x_s3     <= x_s2;
			last_s3  <= last_s2;
			kind_s3  <= kind_s2;
			deriv_s3 <= deriv_s2;
		end
	end

	// Derivative product: t*t for tanh, v*(1-v) otherwise
	always_comb begin
		op_a = (kind_s3 == ACT_LOGISTIC) ? x_s3 : t_s3;
		if (kind_s3 == ACT_TANH) op_b = OPB_W'(t_s3);
		else op_b = OPB_W'(ONE_Y) - OPB_W'(op_a);
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			prod_s4  <= PROD_W'(op_a) * PROD_W'(op_b);
			x_s4     <= x_s3;
			t_s4     <= t_s3;
			lsat_s4  <= lsat_s3;
			last_s4  <= last_s3;
			kind_s4  <= kind_s3;
			deriv_s4 <= deriv_s3;
		end
	end

	// Result select and final clip
	assign shr = YW'(prod_s4 >>> FRAC_BITS);

	always_comb begin
		inv = 1'b0;
		unique case (kind_s4)
			ACT_HEAVISIDE: begin
				if (deriv_s4) begin
					y   = '0;
					inv = 1'b1;
				end else begin
					y = (x_s4 >= 0) ? ONE_Y : '0;
				end
			end
			ACT_LOGISTIC: y = deriv_s4 ? shr : YW'(t_s4);
			ACT_RELU: begin
				if (x_s4 < 0) y = '0;
				else y = deriv_s4 ? ONE_Y : YW'(x_s4);
			end
			ACT_TANH:    y = deriv_s4 ? (ONE_Y - shr) : YW'(t_s4);
			ACT_SIGMOID: y = deriv_s4 ? shr : YW'(t_s4);
			default:     y = deriv_s4 ? ONE_Y : YW'(x_s4);
		endcase
	end

	assign yc = sat_clip(y);

	// Stage 5: output register
	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			out_s5.sample_out <= yc.val;
			out_s5.invalid    <= inv;
			out_s5.saturated  <= yc.sat | lsat_s4;
			out_s5.last_out   <= last_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

endmodule

/* src/afu_interp.sv */
// Table lookup and linear interpolation for sigmoid and tanh, two stages.
// Depends on afu_pkg for the tables, widths and clip helper.
module afu_interp import afu_pkg::*; (
	input  logic                        clk,
	input  interp_en_t                  en,
	input  logic signed [DATA_BITS-1:0] x,
	input  logic                        sel_tanh,
	input  logic                        use_lut,
	output logic signed [DATA_BITS-1:0] t_s3,
	output logic                        lsat_s3
);

	logic [DATA_BITS-1:0]    u;
	logic [IDX_BITS-1:0]     idx;
	logic [IDX_BITS:0]       idx_lo;
	logic [IDX_BITS:0]       idx_hi;
	logic [R_W-1:0]          r;
	logic signed [TAB_W-1:0] ent_a;
	logic signed [TAB_W-1:0] ent_b;

	logic signed [TAB_W-1:0]  a_s2;
	logic signed [DIFF_W-1:0] d_s2;
	logic [R_W-1:0]           r_s2;
	logic                     use_lut_s2;

	logic signed [IPROD_W-1:0] iprod;
	logic signed [YW-1:0]      isum;
	clip_t                     ic;

	// Offset to unsigned, split into segment index and fraction
	assign u      = x ^ {1'b1, {(DATA_BITS-1){1'b0}}};
	assign idx    = u[DATA_BITS-1 -: IDX_BITS];
	assign idx_lo = {1'b0, idx};
	assign idx_hi = idx_lo + (IDX_BITS+1)'(1);
	assign r      = R_W'(u & LERP_MASK);

	// Segment endpoints
	always_comb begin
		if (sel_tanh) begin
			ent_a = $signed(TANH_TAB[idx_lo]);
			ent_b = $signed(TANH_TAB[idx_hi]);
		end else begin
			ent_a = $signed(SIG_TAB[idx_lo]);
			ent_b = $signed(SIG_TAB[idx_hi]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			a_s2       <= ent_a;
			d_s2       <= DIFF_W'(ent_b) - DIFF_W'(ent_a);
			r_s2       <= r;
			use_lut_s2 <= use_lut;
		end
	end

	// a + floor(diff * r / 2^L), then clip
	assign iprod = IPROD_W'(d_s2) * $signed({1'b0, r_s2});
	assign isum  = YW'(a_s2) + YW'(iprod >>> LERP_BITS);
	assign ic    = sat_clip(isum);

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			t_s3    <= ic.val;
			lsat_s3 <= ic.sat & use_lut_s2;
		end
	end

endmodule
